/* rtl/pcop_pkg.sv */
// Shared types, constants and the sine table for the polar circle point generator.
// Used by the front end, the emitter and the top module under rtl; depends on nothing else.
package pcop_pkg;

  localparam int MAX_STEP_DEFAULT       = 45;
  localparam int TRIG_FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH            = 4;

  localparam int STEP_W   = 6;
  localparam int COORD_W  = 10;
  localparam int RADIUS_W = 9;
  localparam int POINT_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Sine table: sin(j deg) for j = 0..90 in unsigned Q1.16, rounded to nearest.
  localparam int TABLE_BITS = 16;
  localparam int TABLE_W    = TABLE_BITS + 1;
  localparam int SIN_LAST   = 90;
  localparam int DEG_W      = 7;

  localparam logic [TABLE_W-1:0] SIN_TABLE [0:SIN_LAST] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } pcop_reg_t;

  // Phase of the last of the eight symmetric points.
  localparam logic [2:0] PHASE_LAST = 3'd7;

  // Base point handed from the front end to the point emitter.
  typedef struct packed {
    logic [RADIUS_W-1:0] a;
    logic [RADIUS_W-1:0] b;
  } pcop_pair_t;

endpackage

/* rtl/pcop_queue.sv */
// Small first-in first-out queue in flip-flops between the front end and the emitter.
// Generic in width and depth; depends on nothing else.
module pcop_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
`endif

endmodule

/* rtl/pcop_front.sv */
// Front end: takes angle steps, looks up cosine and sine, scales them by the radius.
// Three registered stages feeding the queue; uses pcop_pkg.
module pcop_front
  import pcop_pkg::*;
#(
  parameter int MAX_STEP       = MAX_STEP_DEFAULT,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [STEP_W-1:0]   angle_step,
  input  logic [RADIUS_W-1:0] radius,
  output logic                push,
  output pcop_pair_t          push_data,
  input  logic                queue_full
);

  localparam int FACT_W = TRIG_FRAC_BITS + 1;
  localparam int PROD_W = RADIUS_W + FACT_W;
  localparam int UP_SH  = (TRIG_FRAC_BITS >= TABLE_BITS) ? TRIG_FRAC_BITS - TABLE_BITS : 0;
  localparam int DN_SH  = (TRIG_FRAC_BITS < TABLE_BITS) ? TABLE_BITS - TRIG_FRAC_BITS : 0;
  localparam int HALF   = (DN_SH > 0) ? (1 << (DN_SH - 1)) : 0;

  // Rescale a Q1.16 table entry to the working fraction width, rounding when narrowing.
  function automatic logic [FACT_W-1:0] to_factor(input logic [TABLE_W-1:0] t);
    logic [TABLE_W:0] sum;
    sum = {1'b0, t} + (TABLE_W + 1)'(HALF);
    if (TRIG_FRAC_BITS >= TABLE_BITS) begin
      return FACT_W'(t) << UP_SH;
    end else begin
      return FACT_W'(sum >> DN_SH);
    end
  endfunction

  logic              s1_valid;
  logic [STEP_W-1:0] s1_step;
  logic              s2_valid;
  logic              s2_zero;
  logic [FACT_W-1:0] s2_cos;
  logic [FACT_W-1:0] s2_sin;
  logic              s3_valid;
  pcop_pair_t        s3_pair;

  logic s1_take;
  logic s2_take;
  logic s3_take;

  logic [STEP_W-1:0] step_sat;
  logic [DEG_W-1:0]  cos_deg;
  logic [DEG_W-1:0]  sin_deg;
  logic [PROD_W-1:0] prod_cos;
  logic [PROD_W-1:0] prod_sin;

  assign push      = s3_valid && !queue_full;
  assign push_data = s3_pair;
  assign s3_take   = !s3_valid || push;
  assign s2_take   = !s2_valid || s3_take;
  assign s1_take   = !s1_valid || s2_take;
  assign in_ready  = s1_take;

  assign step_sat = (angle_step > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : angle_step;
  assign sin_deg  = DEG_W'(s1_step);
  assign cos_deg  = DEG_W'(SIN_LAST) - DEG_W'(s1_step);
  assign prod_cos = PROD_W'(radius) * PROD_W'(s2_cos);
  assign prod_sin = PROD_W'(radius) * PROD_W'(s2_sin);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_take) s1_valid <= in_valid;
      if (s2_take) s2_valid <= s1_valid;
      if (s3_take) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_step <= step_sat;
    end
    if (s2_take) begin
      s2_zero <= (s1_step == '0);
      s2_cos  <= to_factor(SIN_TABLE[cos_deg]);
      s2_sin  <= to_factor(SIN_TABLE[sin_deg]);
    end
    if (s3_take) begin
      // Step zero takes the point straight above the center: (0, r).
      if (s2_zero) begin
        s3_pair.a <= '0;
        s3_pair.b <= radius;
      end else begin
        s3_pair.a <= prod_cos[TRIG_FRAC_BITS +: RADIUS_W];
        s3_pair.b <= prod_sin[TRIG_FRAC_BITS +: RADIUS_W];
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s3_valid && queue_full |=> s3_valid)
    else $error("front end dropped a stalled base point");
  a_within_radius: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_pair.a <= radius) && (s3_pair.b <= radius))
    else $error("scaled coordinate exceeds the radius");
`endif

endmodule

/* rtl/pcop_emit.sv */
// Point emitter: turns each queued base point into its eight symmetric points.
// Holds the output register; uses pcop_pkg.
module pcop_emit
  import pcop_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  pcop_pair_t                head_data,
  input  logic                      queue_empty,
  output logic                      pop,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POINT_W-1:0] point_x,
  output logic signed [POINT_W-1:0] point_y,
  output logic                      last_point
);

  logic [2:0] phase;
  logic       load;
  logic       take;

  logic [RADIUS_W-1:0]      dx;
  logic [RADIUS_W-1:0]      dy;
  logic signed [POINT_W-1:0] dx_s;
  logic signed [POINT_W-1:0] dy_s;
  logic signed [POINT_W-1:0] off_x;
  logic signed [POINT_W-1:0] off_y;
  logic signed [POINT_W-1:0] point_x_next;
  logic signed [POINT_W-1:0] point_y_next;

  assign load = !out_valid || out_ready;
  assign take = load && !queue_empty;
  assign pop  = take && (phase == PHASE_LAST);

  // The upper four points swap the coordinates; bit 1 negates x, bits 1 xor 0 negate y.
  always_comb begin
    dx    = phase[2] ? head_data.b : head_data.a;
    dy    = phase[2] ? head_data.a : head_data.b;
    dx_s  = signed'({{(POINT_W - RADIUS_W){1'b0}}, dx});
    dy_s  = signed'({{(POINT_W - RADIUS_W){1'b0}}, dy});
    off_x = phase[1] ? -dx_s : dx_s;
    off_y = (phase[1] ^ phase[0]) ? -dy_s : dy_s;
    point_x_next = POINT_W'(center_x) + off_x;
    point_y_next = POINT_W'(center_y) + off_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= '0;
    end else if (load) begin
      out_valid <= !queue_empty;
      if (take) begin
        phase <= phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      point_x    <= point_x_next;
      point_y    <= point_y_next;
      last_point <= (phase == PHASE_LAST);
    end
  end

`ifndef SYNTHESIS
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> phase == '0)
    else $error("last point shown without the phase wrapping");
  a_pop_after_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last_point)
    else $error("base point released before its last point");
`endif

endmodule

/* rtl/polar_circle_octant_points.sv */
// Polar circle point generator. Each angle step transfer (0 to MAX_STEP degrees; larger
// values saturate) yields eight points of the circle around (center_x, center_y) with
// radius radius, in the order (a,b) (a,-b) (-a,-b) (-a,b) (b,a) (b,-a) (-b,-a) (-b,a),
// where a = trunc(r cos k), b = trunc(r sin k), or (0, r) for step zero; the eighth point
// carries last_point. The emitter puts out one point per cycle while out_ready is high
// and base points are queued; the front end takes new steps while earlier ones go out.
// Each step is captured at the transfer, two more front-end stages follow (table lookup,
// multiply), then the queue and the output register. A four-entry queue lets the front
// end keep taking steps while the output is stalled. The user must write the registers
// only while idle; the block itself does not enforce it.
module polar_circle_octant_points
  import pcop_pkg::*;
#(
  parameter int MAX_STEP       = MAX_STEP_DEFAULT,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [STEP_W-1:0]          angle_step,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [POINT_W-1:0]  point_x,
  output logic signed [POINT_W-1:0]  point_y,
  output logic                       last_point
);

  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [RADIUS_W-1:0]       radius;

  logic       push;
  pcop_pair_t push_data;
  logic       pop;
  pcop_pair_t head_data;
  logic       queue_full;
  logic       queue_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= signed'(cfg_data[COORD_W-1:0]);
        REG_CENTER_Y: center_y <= signed'(cfg_data[COORD_W-1:0]);
        REG_RADIUS:   radius   <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  pcop_front #(
    .MAX_STEP       (MAX_STEP),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .angle_step (angle_step),
    .radius     (radius),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  pcop_queue #(
    .WIDTH ($bits(pcop_pair_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  pcop_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .head_data   (head_data),
    .queue_empty (queue_empty),
    .pop         (pop),
    .center_x    (center_x),
    .center_y    (center_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point)
  );

endmodule

/* sim/tb_polar_circle_octant_points.sv */
// Self-checking testbench for polar_circle_octant_points.
// Predicts the eight symmetric circle points of every angle step and compares them field by
// field with the DUT output; depends only on rtl/pcop_pkg.sv and the DUT.
`timescale 1ns / 100ps

module tb_polar_circle_octant_points
  import pcop_pkg::*;
;

  localparam int STEP_LIMIT   = 45;
  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_PASSES    = 10;
  localparam int STEPS_PER_PASS   = 50;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // sin(j deg), j = 0..90, unsigned Q1.16 rounded to nearest.
  localparam int SINE_Q16 [0:90] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  typedef struct {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic                      last;
  } circle_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STEP_W-1:0] angle_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic last_point;

  // Shadow copy of the DUT registers.
  logic signed [COORD_W-1:0] center_x_shadow = '0;
  logic signed [COORD_W-1:0] center_y_shadow = '0;
  logic [RADIUS_W-1:0]       radius_shadow   = '0;

  circle_point_t pending_points [$];
  int mismatches  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit send_idle   = 1'b1;
  bit recv_idle   = 1'b1;

  polar_circle_octant_points #(
    .MAX_STEP       (STEP_LIMIT),
    .TRIG_FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .angle_step (angle_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points outstanding", $time, pending_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short waits, now and then a long one.
  function automatic int pick_wait();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_wait() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Eight symmetric points of one angle step, each offset by the center.
  function automatic void push_octant_points(input logic [STEP_W-1:0] step_in);
    int k;
    int a;
    int b;
    int r;
    int cx;
    int cy;
    int dx [8];
    int dy [8];
    circle_point_t pt;
    k = step_in;
    if (k > STEP_LIMIT) begin
      k = STEP_LIMIT;
    end
    r = radius_shadow;
    cx = center_x_shadow;
    cy = center_y_shadow;
    if (k == 0) begin
      a = 0;
      b = r;
    end else begin
      a = (r * SINE_Q16[90 - k]) >>> FRAC_BITS;
      b = (r * SINE_Q16[k]) >>> FRAC_BITS;
    end
    dx = '{a, a, -a, -a, b, b, -b, -b};
    dy = '{b, -b, -b, b, a, -a, -a, a};
    for (int i = 0; i < 8; i++) begin
      pt.x = POINT_W'(cx + dx[i]);
      pt.y = POINT_W'(cy + dy[i]);
      pt.last = (i == 7);
      pending_points.push_back(pt);
    end
  endfunction

  always @(posedge clk) begin : check_points
    circle_point_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, got x=%0d y=%0d last=%0b",
                 $time, point_x, point_y, last_point);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $display("%0t: point_x expected %0d, got %0d", $time, want.x, point_x);
          mismatches++;
        end
        if (point_y !== want.y) begin
          $display("%0t: point_y expected %0d, got %0d", $time, want.y, point_y);
          mismatches++;
        end
        if (last_point !== want.last) begin
          $display("%0t: last_point expected %0b, got %0b", $time, want.last, last_point);
          mismatches++;
        end
      end
    end
  end

  // Leaves cfg_valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CENTER_X: center_x_shadow = data;
      REG_CENTER_Y: center_y_shadow = data;
      REG_RADIUS:   radius_shadow = data[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                                input logic [CFG_DATA_W-1:0] rad, input bit with_stray);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    if (with_stray) begin
      write_reg(REG_NONE, CFG_DATA_W'($urandom));
    end
    write_reg(REG_RADIUS, rad);
    cfg_valid <= 1'b0;
  endtask

  // Leaves in_valid high when the next step follows without a gap.
  task automatic send_step(input logic [STEP_W-1:0] k);
    int gap;
    gap = 0;
    if (send_idle && $urandom_range(0, 99) < 40) begin
      gap = pick_wait();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_step <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    push_octant_points(k);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    case ($urandom_range(0, 9))
      0: return 10'h200;
      1: return 10'h1FF;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Bit 9 of the radius write is outside the register and is set at random.
  function automatic logic [CFG_DATA_W-1:0] pick_radius();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 9'd0};
      1: return {1'($urandom), 9'h1FF};
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    if ($urandom_range(0, 99) < 85) begin
      return STEP_W'($urandom_range(0, STEP_LIMIT));
    end
    return STEP_W'($urandom_range(STEP_LIMIT + 1, 63));
  endfunction

  // Registers still hold their reset values: every point sits at the origin.
  task automatic test_reset_state();
    send_step(6'd0);
    send_step(6'd45);
    wait_for_idle();
  endtask

  // Largest radius at the corner centers puts points at -1023 and 1022, next to both ends of the point range.
  task automatic test_extreme_points();
    apply_settings(10'h1FF, 10'h200, 10'h1FF, 1'b0);
    send_step(6'd0);
    send_step(6'd1);
    send_step(6'd44);
    send_step(6'd45);
    send_step(6'd46);
    send_step(6'd63);
    wait_for_idle();
    apply_settings(10'h200, 10'h1FF, 10'h3FF, 1'b0);
    send_step(6'd0);
    send_step(6'd30);
    send_step(6'd45);
    wait_for_idle();
    apply_settings(10'h000, 10'h000, 10'h001, 1'b0);
    send_step(6'd0);
    send_step(6'd1);
    send_step(6'd45);
    wait_for_idle();
  endtask

  task automatic test_unused_register();
    write_reg(REG_NONE, 10'h3FF);
    cfg_valid <= 1'b0;
    send_step(6'd45);
    send_step(6'd0);
    wait_for_idle();
  endtask

  task automatic test_random_steps();
    for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
      apply_settings(pick_center(), pick_center(), pick_radius(), $urandom_range(0, 3) == 0);
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      for (int n = 0; n < STEPS_PER_PASS; n++) begin
        send_step(pick_step());
      end
      wait_for_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extreme_points();
    test_unused_register();
    test_random_steps();
    recv_idle = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
